// ===== design/change_record_stream_parser_core_assert.svh =====
// Assertion macros shared by the parser modules
`ifndef CHANGE_RECORD_STREAM_PARSER_CORE_ASSERT_SVH
`define CHANGE_RECORD_STREAM_PARSER_CORE_ASSERT_SVH
`define CRSP_ASSERT_IMPLY(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define CRSP_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

// ===== design/crsp_pkg.sv =====
// Shared types and constants of the change record stream parser
package crsp_pkg;
    localparam int MaxColumns = 2048;
    localparam int CntW = $clog2(MaxColumns + 1);
    localparam int QDepth = 2;

    localparam logic [7:0] TypeBegin    = 8'h42;
    localparam logic [7:0] TypeCommit   = 8'h43;
    localparam logic [7:0] TypeInsert   = 8'h49;
    localparam logic [7:0] TypeUpdate   = 8'h55;
    localparam logic [7:0] TypeDelete   = 8'h44;
    localparam logic [7:0] MarkColumns  = 8'h43;
    localparam logic [7:0] MarkNew      = 8'h4E;
    localparam logic [7:0] MarkKey      = 8'h4B;
    localparam logic [7:0] MarkEnd      = 8'h45;
    localparam logic [7:0] MarkKeyList  = 8'h4D;
    localparam logic [7:0] MarkPrimary  = 8'h50;
    localparam logic [7:0] MarkTuple    = 8'h54;
    localparam logic [7:0] AttNull      = 8'h6E;
    localparam logic [7:0] AttUnchanged = 8'h75;
    localparam logic [7:0] AttText      = 8'h74;

    typedef enum logic [4:0] {
        TK_TYPE = 5'd0, TK_LSN = 5'd1, TK_TIME = 5'd2, TK_XID = 5'd3, TK_END_LSN = 5'd4,
        TK_SCHEMA = 5'd5, TK_REL = 5'd6, TK_NCOLS = 5'd7, TK_COLNAME = 5'd8,
        TK_COLTYPE = 5'd9, TK_NKEYS = 5'd10, TK_KEYNAME = 5'd11, TK_TUPLE = 5'd12,
        TK_NATTS = 5'd13, TK_ATTKIND = 5'd14, TK_TEXT = 5'd15, TK_ERROR = 5'd16
    } t_kind;

    typedef enum logic [3:0] {
        ER_NONE = 4'd0, ER_TYPE = 4'd1, ER_FLAGS = 4'd2, ER_MARKER = 4'd3,
        ER_NOT_T = 4'd4, ER_KIND = 4'd5, ER_KEY_MARK = 4'd6, ER_TOO_MANY = 4'd7,
        ER_TRUNC = 4'd8
    } t_err;

    typedef enum logic [2:0] {
        MK_BEGIN = 3'd0, MK_COMMIT = 3'd1, MK_INSERT = 3'd2, MK_UPDATE = 3'd3,
        MK_DELETE = 3'd4
    } t_msg;

    typedef enum logic [30:0] {
        PH_IDLE        = 31'h0000_0001,
        PH_DONE        = 31'h0000_0002,
        PH_BEG_FLAGS   = 31'h0000_0004,
        PH_BEG_LSN     = 31'h0000_0008,
        PH_BEG_TIME    = 31'h0000_0010,
        PH_BEG_XID     = 31'h0000_0020,
        PH_COM_FLAGS   = 31'h0000_0040,
        PH_COM_LSN     = 31'h0000_0080,
        PH_COM_END     = 31'h0000_0100,
        PH_COM_TIME    = 31'h0000_0200,
        PH_NSP_LEN     = 31'h0000_0400,
        PH_NSP_STR     = 31'h0000_0800,
        PH_REL_LEN     = 31'h0000_1000,
        PH_REL_STR     = 31'h0000_2000,
        PH_MARK1       = 31'h0000_4000,
        PH_MARK2       = 31'h0000_8000,
        PH_COL_N       = 31'h0001_0000,
        PH_COL_LEN     = 31'h0002_0000,
        PH_COL_NAME    = 31'h0004_0000,
        PH_COL_TLEN    = 31'h0008_0000,
        PH_COL_TYPE    = 31'h0010_0000,
        PH_KEY_MARK    = 31'h0020_0000,
        PH_KEY_N       = 31'h0040_0000,
        PH_KEY_LEN     = 31'h0080_0000,
        PH_KEY_NAME    = 31'h0100_0000,
        PH_TUP_T       = 31'h0200_0000,
        PH_TUP_NATTS   = 31'h0400_0000,
        PH_ATT_KIND    = 31'h0800_0000,
        PH_ATT_LEN     = 31'h1000_0000,
        PH_ATT_TEXT    = 31'h2000_0000,
        PH_UPD_NEWMARK = 31'h4000_0000
    } t_phase;

    // class of one byte, decided by the front end
    typedef enum logic [5:0] {
        CL_TYPE  = 6'b000001,
        CL_STR   = 6'b000010,
        CL_INT   = 6'b000100,
        CL_MARK  = 6'b001000,
        CL_DROP  = 6'b010000,
        CL_OTHER = 6'b100000
    } t_class;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        t_class     cls;
    } t_word;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic [10:0] index;
        t_err        err;
        logic        slast;
        logic        mend;
    } t_token;
endpackage

// ===== design/crsp_front.sv =====
// Front end: accept bytes, classify them, push words into a short queue
module crsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_first_byte,
    input  logic              i_final_byte,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output crsp_pkg::t_word   o_q_word
);
    localparam int AW = $clog2(crsp_pkg::QDepth);
    crsp_pkg::t_word r_mem [crsp_pkg::QDepth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic push;
    crsp_pkg::t_word w;

    always_comb begin
        w.data  = i_data_byte;
        w.first = i_first_byte;
        w.last  = i_final_byte;
        w.cls   = i_first_byte ? crsp_pkg::CL_TYPE : crsp_pkg::CL_OTHER;
    end

    assign o_stall   = (r_cnt == (AW+1)'(crsp_pkg::QDepth));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= w;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(i_q_pop);
        end
    end

    `include "change_record_stream_parser_core_assert.svh"
    `CRSP_ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, i_q_pop, o_q_valid)
    `CRSP_ASSERT_IMPLY(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= (AW+1)'(crsp_pkg::QDepth))
    `CRSP_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, push && !i_q_pop, r_cnt != '0)
endmodule

// ===== design/crsp_back.sv =====
// Back end: run the parse phase machine and register a token for each word that yields one
module crsp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_pop,
    input  crsp_pkg::t_word  i_q_word,
    output logic             o_valid,
    input  logic             i_stall,
    output crsp_pkg::t_token o_token
);
    localparam int CW = crsp_pkg::CntW;
    crsp_pkg::t_phase r_ph, n_ph;
    crsp_pkg::t_msg   r_mk, n_mk;
    logic [31:0] r_left, n_left;
    logic [63:0] r_acc, n_acc;
    logic [CW-1:0] r_idx, n_idx, r_tot, n_tot;
    logic r_new, n_new, r_drop, n_drop;
    logic r_ov, n_ov;
    crsp_pkg::t_token r_tok, n_tok;
    logic have, go;
    logic [7:0] b;
    logic [63:0] v;
    logic [CW-1:0] idx1;
    crsp_pkg::t_phase tdone;

    assign b = i_q_word.data;
    assign o_q_pop = i_q_valid && (!r_ov || !i_stall);
    assign go = o_q_pop;
    assign o_valid = r_ov;
    assign o_token = r_tok;
    assign v = {r_acc[55:0], b};
    assign idx1 = r_idx + 1'b1;
    assign tdone = (r_mk == crsp_pkg::MK_UPDATE && !r_new) ? crsp_pkg::PH_UPD_NEWMARK
                                                         : crsp_pkg::PH_DONE;

    always_comb begin
        n_ph = r_ph; n_mk = r_mk; n_left = r_left; n_acc = r_acc;
        n_idx = r_idx; n_tot = r_tot; n_new = r_new; n_drop = r_drop;
        have = 1'b0;
        n_tok = '{kind: crsp_pkg::TK_TYPE, value: '0, index: '0,
                  err: crsp_pkg::ER_NONE, slast: 1'b0, mend: 1'b0};
        if (i_q_word.first) begin
            n_idx = '0; n_tot = '0; n_new = 1'b0; n_drop = 1'b0;
            n_acc = '0; have = 1'b1;
            case (b)
                crsp_pkg::TypeBegin: begin
                    n_mk = crsp_pkg::MK_BEGIN; n_ph = crsp_pkg::PH_BEG_FLAGS; n_left = 32'd4;
                end
                crsp_pkg::TypeCommit: begin
                    n_mk = crsp_pkg::MK_COMMIT; n_ph = crsp_pkg::PH_COM_FLAGS; n_left = 32'd4;
                end
                crsp_pkg::TypeInsert: begin
                    n_mk = crsp_pkg::MK_INSERT; n_ph = crsp_pkg::PH_NSP_LEN; n_left = 32'd2;
                end
                crsp_pkg::TypeUpdate: begin
                    n_mk = crsp_pkg::MK_UPDATE; n_ph = crsp_pkg::PH_NSP_LEN; n_left = 32'd2;
                end
                crsp_pkg::TypeDelete: begin
                    n_mk = crsp_pkg::MK_DELETE; n_ph = crsp_pkg::PH_NSP_LEN; n_left = 32'd2;
                end
                default: begin
                    n_mk = crsp_pkg::MK_BEGIN; n_ph = crsp_pkg::PH_IDLE; n_drop = 1'b1;
                    n_tok.kind = crsp_pkg::TK_ERROR; n_tok.err = crsp_pkg::ER_TYPE;
                end
            endcase
            if (n_tok.kind != crsp_pkg::TK_ERROR) begin
                n_tok.value = 64'(n_mk);
            end
        end else begin
            case (r_ph)
                crsp_pkg::PH_IDLE, crsp_pkg::PH_DONE: ;
                crsp_pkg::PH_NSP_STR, crsp_pkg::PH_REL_STR, crsp_pkg::PH_COL_NAME,
                crsp_pkg::PH_COL_TYPE, crsp_pkg::PH_KEY_NAME, crsp_pkg::PH_ATT_TEXT: begin
                    have = 1'b1;
                    n_tok.value = 64'(b);
                    n_tok.slast = (r_left == 32'd1);
                    n_tok.index = 11'(r_idx);
                    case (r_ph)
                        crsp_pkg::PH_NSP_STR: begin n_tok.kind = crsp_pkg::TK_SCHEMA; n_tok.index = '0; end
                        crsp_pkg::PH_REL_STR: begin n_tok.kind = crsp_pkg::TK_REL; n_tok.index = '0; end
                        crsp_pkg::PH_COL_NAME: n_tok.kind = crsp_pkg::TK_COLNAME;
                        crsp_pkg::PH_COL_TYPE: n_tok.kind = crsp_pkg::TK_COLTYPE;
                        crsp_pkg::PH_KEY_NAME: n_tok.kind = crsp_pkg::TK_KEYNAME;
                        default: n_tok.kind = crsp_pkg::TK_TEXT;
                    endcase
                    n_left = r_left - 1'b1;
                    if (r_left == 32'd1) begin
                        n_acc = '0;
                        case (r_ph)
                            crsp_pkg::PH_NSP_STR: begin n_ph = crsp_pkg::PH_REL_LEN; n_left = 32'd2; end
                            crsp_pkg::PH_REL_STR: n_ph = crsp_pkg::PH_MARK1;
                            crsp_pkg::PH_COL_NAME: begin n_ph = crsp_pkg::PH_COL_TLEN; n_left = 32'd2; end
                            crsp_pkg::PH_COL_TYPE: begin
                                n_idx = idx1;
                                if (idx1 >= r_tot) n_ph = crsp_pkg::PH_KEY_MARK;
                                else begin n_ph = crsp_pkg::PH_COL_LEN; n_left = 32'd2; end
                            end
                            crsp_pkg::PH_KEY_NAME: begin
                                n_idx = idx1;
                                if (idx1 >= r_tot) n_ph = crsp_pkg::PH_MARK2;
                                else begin n_ph = crsp_pkg::PH_KEY_LEN; n_left = 32'd2; end
                            end
                            default: begin
                                n_idx = idx1;
                                n_ph = (idx1 >= r_tot) ? tdone : crsp_pkg::PH_ATT_KIND;
                            end
                        endcase
                    end
                end
                crsp_pkg::PH_MARK1, crsp_pkg::PH_MARK2, crsp_pkg::PH_UPD_NEWMARK: begin
                    if (r_ph == crsp_pkg::PH_MARK1 && b == crsp_pkg::MarkColumns) begin
                        n_ph = crsp_pkg::PH_COL_N; n_left = 32'd2; n_acc = '0;
                    end else if (b == crsp_pkg::MarkNew && (r_mk == crsp_pkg::MK_UPDATE ||
                             (r_mk == crsp_pkg::MK_INSERT && r_ph != crsp_pkg::PH_UPD_NEWMARK))) begin
                        n_new = 1'b1; n_ph = crsp_pkg::PH_TUP_T;
                    end else if (r_ph != crsp_pkg::PH_UPD_NEWMARK && b == crsp_pkg::MarkKey &&
                             (r_mk == crsp_pkg::MK_UPDATE || r_mk == crsp_pkg::MK_DELETE)) begin
                        n_new = 1'b0; n_ph = crsp_pkg::PH_TUP_T;
                    end else if (r_ph != crsp_pkg::PH_UPD_NEWMARK && b == crsp_pkg::MarkEnd &&
                             r_mk == crsp_pkg::MK_DELETE) begin
                        n_ph = crsp_pkg::PH_DONE;
                    end else begin
                        have = 1'b1; n_ph = crsp_pkg::PH_IDLE; n_drop = 1'b1;
                        n_tok.kind = crsp_pkg::TK_ERROR; n_tok.err = crsp_pkg::ER_MARKER;
                    end
                end
                crsp_pkg::PH_KEY_MARK: begin
                    if (b == crsp_pkg::MarkPrimary) n_ph = crsp_pkg::PH_MARK2;
                    else if (b == crsp_pkg::MarkKeyList) begin
                        n_ph = crsp_pkg::PH_KEY_N; n_left = 32'd2; n_acc = '0;
                    end else begin
                        have = 1'b1; n_ph = crsp_pkg::PH_IDLE; n_drop = 1'b1;
                        n_tok.kind = crsp_pkg::TK_ERROR; n_tok.err = crsp_pkg::ER_KEY_MARK;
                    end
                end
                crsp_pkg::PH_TUP_T: begin
                    have = 1'b1;
                    if (b == crsp_pkg::MarkTuple) begin
                        n_tok.kind = crsp_pkg::TK_TUPLE; n_tok.value = 64'(r_new);
                        n_ph = crsp_pkg::PH_TUP_NATTS; n_left = 32'd4; n_acc = '0;
                    end else begin
                        n_ph = crsp_pkg::PH_IDLE; n_drop = 1'b1;
                        n_tok.kind = crsp_pkg::TK_ERROR; n_tok.err = crsp_pkg::ER_NOT_T;
                    end
                end
                crsp_pkg::PH_ATT_KIND: begin
                    have = 1'b1;
                    n_tok.kind = crsp_pkg::TK_ATTKIND; n_tok.value = 64'(b);
                    n_tok.index = 11'(r_idx);
                    if (b == crsp_pkg::AttNull || b == crsp_pkg::AttUnchanged) begin
                        n_idx = idx1;
                        n_ph = (idx1 >= r_tot) ? tdone : crsp_pkg::PH_ATT_KIND;
                    end else if (b == crsp_pkg::AttText) begin
                        n_ph = crsp_pkg::PH_ATT_LEN; n_left = 32'd4; n_acc = '0;
                    end else begin
                        n_tok = '{kind: crsp_pkg::TK_ERROR, value: '0, index: '0,
                                  err: crsp_pkg::ER_KIND, slast: 1'b0, mend: 1'b0};
                        n_ph = crsp_pkg::PH_IDLE; n_drop = 1'b1;
                    end
                end
                default: begin
                    n_acc = v;
                    if (r_left > 32'd1 ) n_left = r_left - 1'b1;
                    else begin
                        n_left = '0;
                        n_acc = '0;
                        case (r_ph)
                            crsp_pkg::PH_BEG_FLAGS: begin n_ph = crsp_pkg::PH_BEG_LSN; n_left = 32'd8; end
                            crsp_pkg::PH_BEG_LSN: begin have = 1'b1; n_tok.kind = crsp_pkg::TK_LSN; n_tok.value = v; n_ph = crsp_pkg::PH_BEG_TIME; n_left = 32'd8; end
                            crsp_pkg::PH_BEG_TIME: begin have = 1'b1; n_tok.kind = crsp_pkg::TK_TIME; n_tok.value = v; n_ph = crsp_pkg::PH_BEG_XID; n_left = 32'd4; end
                            crsp_pkg::PH_BEG_XID: begin have = 1'b1; n_tok.kind = crsp_pkg::TK_XID; n_tok.value = v; n_ph = crsp_pkg::PH_DONE; end
                            crsp_pkg::PH_COM_FLAGS: begin
                                if (v != '0) begin
                                    have = 1'b1; n_ph = crsp_pkg::PH_IDLE; n_drop = 1'b1;
                                    n_tok.kind = crsp_pkg::TK_ERROR; n_tok.err = crsp_pkg::ER_FLAGS;
                                end else begin n_ph = crsp_pkg::PH_COM_LSN; n_left = 32'd8; end
                            end
                            crsp_pkg::PH_COM_LSN: begin have = 1'b1; n_tok.kind = crsp_pkg::TK_LSN; n_tok.value = v; n_ph = crsp_pkg::PH_COM_END; n_left = 32'd8; end
                            crsp_pkg::PH_COM_END: begin have = 1'b1; n_tok.kind = crsp_pkg::TK_END_LSN; n_tok.value = v; n_ph = crsp_pkg::PH_COM_TIME; n_left = 32'd8; end
                            crsp_pkg::PH_COM_TIME: begin have = 1'b1; n_tok.kind = crsp_pkg::TK_TIME; n_tok.value = v; n_ph = crsp_pkg::PH_DONE; end
                            crsp_pkg::PH_COL_N, crsp_pkg::PH_KEY_N, crsp_pkg::PH_TUP_NATTS: begin
                                have = 1'b1;
                                if (v > 64'(crsp_pkg::MaxColumns)) begin
                                    n_ph = crsp_pkg::PH_IDLE; n_drop = 1'b1;
                                    n_tok.kind = crsp_pkg::TK_ERROR; n_tok.err = crsp_pkg::ER_TOO_MANY;
                                end else begin
                                    n_tok.value = v;
                                    n_tot = CW'(v); n_idx = '0;
                                    case (r_ph)
                                        crsp_pkg::PH_COL_N: begin
                                            n_tok.kind = crsp_pkg::TK_NCOLS;
                                            if (v == '0) n_ph = crsp_pkg::PH_KEY_MARK;
                                            else begin n_ph = crsp_pkg::PH_COL_LEN; n_left = 32'd2; end
                                        end
                                        crsp_pkg::PH_KEY_N: begin
                                            n_tok.kind = crsp_pkg::TK_NKEYS;
                                            if (v == '0) n_ph = crsp_pkg::PH_MARK2;
                                            else begin n_ph = crsp_pkg::PH_KEY_LEN; n_left = 32'd2; end
                                        end
                                        default: begin
                                            n_tok.kind = crsp_pkg::TK_NATTS;
                                            n_ph = (v == '0) ? tdone : crsp_pkg::PH_ATT_KIND;
                                        end
                                    endcase
                                end
                            end
                            default: begin
                                // string length: zero length finishes the item at once
                                if (v == '0 || (r_ph == crsp_pkg::PH_COL_LEN && v[15:0] == '0)) begin
                                    case (r_ph)
                                        crsp_pkg::PH_NSP_LEN: begin n_ph = crsp_pkg::PH_REL_LEN; n_left = 32'd2; end
                                        crsp_pkg::PH_REL_LEN: n_ph = crsp_pkg::PH_MARK1;
                                        crsp_pkg::PH_COL_TLEN, crsp_pkg::PH_COL_LEN: begin
                                            n_idx = idx1;
                                            if (idx1 >= r_tot) n_ph = crsp_pkg::PH_KEY_MARK;
                                            else begin n_ph = crsp_pkg::PH_COL_LEN; n_left = 32'd2; end
                                        end
                                        crsp_pkg::PH_KEY_LEN: begin
                                            n_idx = idx1;
                                            if (idx1 >= r_tot) n_ph = crsp_pkg::PH_MARK2;
                                            else begin n_ph = crsp_pkg::PH_KEY_LEN; n_left = 32'd2; end
                                        end
                                        default: begin
                                            n_idx = idx1;
                                            n_ph = (idx1 >= r_tot) ? tdone : crsp_pkg::PH_ATT_KIND;
                                        end
                                    endcase
                                end else begin
                                    n_left = v[31:0];
                                    case (r_ph)
                                        crsp_pkg::PH_NSP_LEN: n_ph = crsp_pkg::PH_NSP_STR;
                                        crsp_pkg::PH_REL_LEN: n_ph = crsp_pkg::PH_REL_STR;
                                        crsp_pkg::PH_COL_LEN: n_ph = crsp_pkg::PH_COL_NAME;
                                        crsp_pkg::PH_COL_TLEN: n_ph = crsp_pkg::PH_COL_TYPE;
                                        crsp_pkg::PH_KEY_LEN: n_ph = crsp_pkg::PH_KEY_NAME;
                                        default: n_ph = crsp_pkg::PH_ATT_TEXT;
                                    endcase
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
        if (i_q_word.last && n_ph != crsp_pkg::PH_IDLE && n_ph != crsp_pkg::PH_DONE) begin
            have = 1'b1; n_ph = crsp_pkg::PH_IDLE; n_drop = 1'b1;
            n_tok = '{kind: crsp_pkg::TK_ERROR, value: '0, index: '0,
                      err: crsp_pkg::ER_TRUNC, slast: 1'b0, mend: 1'b0};
        end
        if (n_tok.kind == crsp_pkg::TK_ERROR) begin
            n_tok.value = '0; n_tok.index = '0; n_tok.slast = 1'b0;
        end
        n_tok.mend = (n_tok.kind == crsp_pkg::TK_ERROR) || (n_ph == crsp_pkg::PH_DONE);
        n_ov = r_ov && i_stall;
        if (go && have) n_ov = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (go && have) begin
            r_tok <= n_tok;
        end
        if (!i_rst_n) begin
            r_ph <= crsp_pkg::PH_IDLE; r_mk <= crsp_pkg::MK_BEGIN; r_left <= '0;
            r_acc <= '0; r_idx <= '0; r_tot <= '0; r_new <= 1'b0; r_drop <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
            if (go) begin
                r_ph <= n_ph; r_mk <= n_mk; r_left <= n_left; r_acc <= n_acc;
                r_idx <= n_idx; r_tot <= n_tot; r_new <= n_new; r_drop <= n_drop;
            end
        end
    end

    `include "change_record_stream_parser_core_assert.svh"
    `CRSP_ASSERT_IMPLY(a_idx_bound, i_clk, i_rst_n, 1'b1, r_idx <= r_tot)
    `CRSP_ASSERT_IMPLY(a_err_ends, i_clk, i_rst_n, r_ov && r_tok.kind == crsp_pkg::TK_ERROR, r_tok.mend)
    `CRSP_ASSERT_NEXT(a_hold_tok, i_clk, i_rst_n, r_ov && i_stall, r_ov && $stable(r_tok))
endmodule

// ===== design/change_record_stream_parser_core.sv =====
// Top level of the change record stream parser
// A byte's token passes through the word queue and then the token register.
// One byte per cycle while the queue has room; the phase machine handles one word a cycle unless the output stalls.
// A two-entry word queue lets the front accept while the output stalls.
// Reset: synchronous active-low; clears queue, phase state and output valid.
module change_record_stream_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_token_kind,
    output logic [63:0] o_token_value,
    output logic [10:0] o_item_index,
    output logic [3:0]  o_error_code,
    output logic        o_string_last,
    output logic        o_message_end
);
    logic q_valid, q_pop;
    crsp_pkg::t_word q_word;
    crsp_pkg::t_token tok;

    crsp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data_byte(i_data_byte), .i_first_byte(i_first_byte),
        .i_final_byte(i_final_byte), .o_q_valid(q_valid), .i_q_pop(q_pop),
        .o_q_word(q_word)
    );

    crsp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_word(q_word), .o_valid(o_valid), .i_stall(i_stall), .o_token(tok)
    );

    assign o_token_kind  = tok.kind;
    assign o_token_value = tok.value;
    assign o_item_index  = tok.index;
    assign o_error_code  = tok.err;
    assign o_string_last = tok.slast;
    assign o_message_end = tok.mend;
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the change record stream parser core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import crsp_pkg::*;

    localparam int CycleLimit = 600000;

    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
    } byte_item_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_first_byte;
    logic        i_final_byte;
    logic        o_valid;
    logic        i_stall;
    logic [4:0]  o_token_kind;
    logic [63:0] o_token_value;
    logic [10:0] o_item_index;
    logic [3:0]  o_error_code;
    logic        o_string_last;
    logic        o_message_end;

    change_record_stream_parser_core i_dut (.*);

    byte_item_t  pending_bytes[$];
    logic [7:0]  msg_bytes[$];
    t_token      token_q[$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          tokens_seen = 0;
    int          error_tokens = 0;
    int          cycles = 0;
    int          send_wait = 0;
    int          send_calm = 0;
    int          recv_calm = 0;
    int          recv_wait = 0;

    t_phase      ph;
    t_msg        mk;
    logic [31:0] left;
    logic [63:0] acc;
    logic [31:0] eidx;
    logic [31:0] etot;
    logic        tnew;
    logic        drop;
    bit          have;
    t_token      tk;

    function automatic void tok(t_kind k, logic [63:0] v, logic [31:0] idx, logic last);
        have = 1;
        tk.kind = k;
        tk.value = v;
        tk.index = idx[10:0];
        tk.err = ER_NONE;
        tk.slast = last;
    endfunction

    function automatic void abort(t_err e);
        have = 1;
        tk.kind = TK_ERROR;
        tk.value = '0;
        tk.index = '0;
        tk.err = e;
        tk.slast = 0;
        ph = PH_IDLE;
        drop = 1;
    endfunction

    function automatic void start_int(t_phase p, int n);
        ph = p;
        left = n;
        acc = '0;
    endfunction

    function automatic void tuple_done();
        if (mk == MK_UPDATE && !tnew) ph = PH_UPD_NEWMARK;
        else ph = PH_DONE;
    endfunction

    function automatic void next_column();
        eidx++;
        if (eidx >= etot) ph = PH_KEY_MARK;
        else start_int(PH_COL_LEN, 2);
    endfunction

    function automatic void next_key();
        eidx++;
        if (eidx >= etot) ph = PH_MARK2;
        else start_int(PH_KEY_LEN, 2);
    endfunction

    function automatic void next_att();
        eidx++;
        if (eidx >= etot) tuple_done();
        else ph = PH_ATT_KIND;
    endfunction

    function automatic void string_done(t_phase p);
        case (p)
            PH_NSP_STR: start_int(PH_REL_LEN, 2);
            PH_REL_STR: ph = PH_MARK1;
            PH_COL_NAME: start_int(PH_COL_TLEN, 2);
            PH_COL_TYPE: next_column();
            PH_KEY_NAME: next_key();
            default: next_att();
        endcase
    endfunction

    function automatic void start_str(t_phase p, logic [63:0] len);
        if (len == 0) begin
            string_done(p);
        end else begin
            ph = p;
            left = len[31:0];
        end
    endfunction

    function automatic void start_list(logic [63:0] v, t_kind k, t_phase fp, bit is_int);
        if (v > MaxColumns) begin
            abort(ER_TOO_MANY);
        end else begin
            tok(k, v, 0, 0);
            etot = v[31:0];
            eidx = 0;
            if (v == 0) begin
                if (k == TK_NCOLS) ph = PH_KEY_MARK;
                else if (k == TK_NKEYS) ph = PH_MARK2;
                else tuple_done();
            end else if (is_int) begin
                start_int(fp, 2);
            end else begin
                ph = fp;
            end
        end
    endfunction

    function automatic void int_done(t_phase p, logic [63:0] v);
        case (p)
            PH_BEG_FLAGS: start_int(PH_BEG_LSN, 8);
            PH_BEG_LSN: begin tok(TK_LSN, v, 0, 0); start_int(PH_BEG_TIME, 8); end
            PH_BEG_TIME: begin tok(TK_TIME, v, 0, 0); start_int(PH_BEG_XID, 4); end
            PH_BEG_XID: begin tok(TK_XID, v, 0, 0); ph = PH_DONE; end
            PH_COM_FLAGS: begin
                if (v != 0) abort(ER_FLAGS);
                else start_int(PH_COM_LSN, 8);
            end
            PH_COM_LSN: begin tok(TK_LSN, v, 0, 0); start_int(PH_COM_END, 8); end
            PH_COM_END: begin tok(TK_END_LSN, v, 0, 0); start_int(PH_COM_TIME, 8); end
            PH_COM_TIME: begin tok(TK_TIME, v, 0, 0); ph = PH_DONE; end
            PH_NSP_LEN: start_str(PH_NSP_STR, v);
            PH_REL_LEN: start_str(PH_REL_STR, v);
            PH_COL_N: start_list(v, TK_NCOLS, PH_COL_LEN, 1);
            PH_COL_LEN: begin
                if (v == 0) next_column();
                else start_str(PH_COL_NAME, v);
            end
            PH_COL_TLEN: start_str(PH_COL_TYPE, v);
            PH_KEY_N: start_list(v, TK_NKEYS, PH_KEY_LEN, 1);
            PH_KEY_LEN: start_str(PH_KEY_NAME, v);
            PH_TUP_NATTS: start_list(v, TK_NATTS, PH_ATT_KIND, 0);
            default: start_str(PH_ATT_TEXT, v);
        endcase
    endfunction

    function automatic void start_tuple(logic is_new);
        tnew = is_new;
        ph = PH_TUP_T;
    endfunction

    function automatic void marker(logic [7:0] b, bit allow_c);
        if (allow_c && b == "C") begin
            start_int(PH_COL_N, 2);
            return;
        end
        case (mk)
            MK_INSERT: if (b == "N") begin start_tuple(1); return; end
            MK_UPDATE: begin
                if (b == "N") begin start_tuple(1); return; end
                if (b == "K") begin start_tuple(0); return; end
            end
            MK_DELETE: begin
                if (b == "K") begin start_tuple(0); return; end
                if (b == "E") begin ph = PH_DONE; return; end
            end
            default: ;
        endcase
        abort(ER_MARKER);
    endfunction

    function automatic void type_byte(logic [7:0] b);
        eidx = 0;
        etot = 0;
        tnew = 0;
        drop = 0;
        case (b)
            "B": begin mk = MK_BEGIN; start_int(PH_BEG_FLAGS, 4); end
            "C": begin mk = MK_COMMIT; start_int(PH_COM_FLAGS, 4); end
            "I": begin mk = MK_INSERT; start_int(PH_NSP_LEN, 2); end
            "U": begin mk = MK_UPDATE; start_int(PH_NSP_LEN, 2); end
            "D": begin mk = MK_DELETE; start_int(PH_NSP_LEN, 2); end
            default: begin mk = MK_BEGIN; abort(ER_TYPE); return; end
        endcase
        tok(TK_TYPE, 64'(mk), 0, 0);
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic first, logic final_b);
        t_phase p;
        t_kind  k;
        have = 0;
        if (first) begin
            type_byte(b);
        end else begin
            p = ph;
            case (p)
                PH_IDLE, PH_DONE: return;
                PH_NSP_STR, PH_REL_STR, PH_COL_NAME, PH_COL_TYPE, PH_KEY_NAME,
                PH_ATT_TEXT: begin
                    k = p == PH_NSP_STR ? TK_SCHEMA : p == PH_REL_STR ? TK_REL :
                        p == PH_COL_NAME ? TK_COLNAME : p == PH_COL_TYPE ? TK_COLTYPE :
                        p == PH_KEY_NAME ? TK_KEYNAME : TK_TEXT;
                    tok(k, 64'(b), (p == PH_NSP_STR || p == PH_REL_STR) ? 0 : eidx,
                        left == 1);
                    left--;
                    if (left == 0) string_done(p);
                end
                PH_MARK1: marker(b, 1);
                PH_MARK2: marker(b, 0);
                PH_UPD_NEWMARK: begin
                    if (b == "N") start_tuple(1);
                    else abort(ER_MARKER);
                end
                PH_KEY_MARK: begin
                    if (b == "P") ph = PH_MARK2;
                    else if (b == "M") start_int(PH_KEY_N, 2);
                    else abort(ER_KEY_MARK);
                end
                PH_TUP_T: begin
                    if (b == "T") begin
                        tok(TK_TUPLE, 64'(tnew), 0, 0);
                        start_int(PH_TUP_NATTS, 4);
                    end else begin
                        abort(ER_NOT_T);
                    end
                end
                PH_ATT_KIND: begin
                    if (b == "n" || b == "u") begin
                        tok(TK_ATTKIND, 64'(b), eidx, 0);
                        next_att();
                    end else if (b == "t") begin
                        tok(TK_ATTKIND, 64'(b), eidx, 0);
                        start_int(PH_ATT_LEN, 4);
                    end else begin
                        abort(ER_KIND);
                    end
                end
                default: begin
                    acc = {acc[55:0], b};
                    if (left > 0) left--;
                    if (left == 0) int_done(p, acc);
                end
            endcase
        end
        if (final_b && ph != PH_IDLE && ph != PH_DONE) abort(ER_TRUNC);
        if (have) begin
            tk.mend = (tk.kind == TK_ERROR) || (ph == PH_DONE);
            token_q.push_back(tk);
        end
    endfunction

    function automatic int pick_wait(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(999);
        if (r < 5) calm = $urandom_range(200, 50);
        if (r < 650) return 0;
        if (r < 960) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic put8(logic [7:0] v);
        msg_bytes.push_back(v);
    endtask

    task automatic put_n(logic [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--) msg_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic put_str(int len);
        put_n(len, 2);
        for (int i = 0; i < len; i++) put8($urandom);
    endtask

    task automatic put_rand(int n);
        for (int i = 0; i < n; i++) put8($urandom);
    endtask

    task automatic put_tuple(int n);
        int kd;
        int len;
        put8("T");
        put_n(n, 4);
        for (int i = 0; i < n; i++) begin
            kd = $urandom_range(2);
            put8(kd == 0 ? "n" : kd == 1 ? "u" : "t");
            if (kd == 2) begin
                len = $urandom_range(3);
                put_n(len, 4);
                put_rand(len);
            end
        end
    endtask

    task automatic put_columns();
        int n;
        int len;
        put8("C");
        n = $urandom_range(3);
        put_n(n, 2);
        for (int i = 0; i < n; i++) begin
            len = $urandom_range(2);
            put_str(len);
            if (len > 0) put_str($urandom_range(2));
        end
        if ($urandom_range(1)) begin
            put8("P");
        end else begin
            put8("M");
            n = $urandom_range(2);
            put_n(n, 2);
            for (int i = 0; i < n; i++) put_str($urandom_range(2));
        end
    endtask

    task automatic send_msg(bit mark_last);
        for (int i = 0; i < msg_bytes.size(); i++)
            pending_bytes.push_back('{msg_bytes[i], i == 0,
                                      mark_last && i == msg_bytes.size() - 1});
        msg_bytes.delete();
    endtask

    task automatic build_random_msg();
        int sel;
        sel = $urandom_range(4);
        case (sel)
            0: begin put8("B"); put_rand(24); end
            1: begin
                put8("C");
                put_n(($urandom_range(15) == 0) ? 64'($urandom) : 64'd0, 4);
                put_rand(24);
            end
            default: begin
                put8(sel == 2 ? "I" : sel == 3 ? "U" : "D");
                put_str($urandom_range(2));
                put_str($urandom_range(3));
                if ($urandom_range(2) == 0) put_columns();
                if (sel == 2) begin
                    put8("N");
                    put_tuple($urandom_range(4));
                end else if (sel == 3) begin
                    if ($urandom_range(1)) begin
                        put8("K");
                        put_tuple($urandom_range(3));
                    end
                    put8("N");
                    put_tuple($urandom_range(4));
                end else if ($urandom_range(1)) begin
                    put8("K");
                    put_tuple($urandom_range(3));
                end else begin
                    put8("E");
                end
            end
        endcase
    endtask

    task automatic add_random_msg();
        int r;
        int pos;
        build_random_msg();
        r = $urandom_range(99);
        if (r < 8 && msg_bytes.size() > 1) begin
            pos = $urandom_range(msg_bytes.size() - 1, 1);
            while (msg_bytes.size() > pos) void'(msg_bytes.pop_back());
        end else if (r < 16) begin
            pos = $urandom_range(msg_bytes.size() - 1);
            msg_bytes[pos] = $urandom;
        end
        send_msg($urandom_range(19) != 0);
        if ($urandom_range(15) == 0)
            for (int i = $urandom_range(3, 1); i > 0; i--)
                pending_bytes.push_back('{8'($urandom), 1'b0, 1'($urandom)});
    endtask

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_data_byte = '0;
        i_first_byte = 0;
        i_final_byte = 0;
        i_stall = 0;
        ph = PH_IDLE;
        mk = MK_BEGIN;
        left = '0;
        acc = '0;
        eidx = '0;
        etot = '0;
        tnew = 0;
        drop = 0;

        put8("B"); put_n('1, 4); put_n('1, 8); put_n('1, 8); put_n('1, 4); send_msg(1);
        put8("B"); put_n(0, 24); send_msg(1);
        put8("C"); put_n(0, 4); put_rand(24); send_msg(1);
        put8("C"); put_n(1, 4); put_rand(24); send_msg(1);
        put8("X"); put_rand(3); send_msg(1);
        put8("I"); put_n(0, 2); put_n(1, 2); put8("a");
        put8("C"); put_n(2, 2); put_n(0, 2); put_n(1, 2); put8("x"); put_n(1, 2); put8("y");
        put8("M"); put_n(1, 2); put_n(1, 2); put8("k");
        put8("N"); put8("T"); put_n(3, 4); put8("n"); put8("u"); put8("t");
        put_n(2, 4); put8(8'h00); put8(8'hff); send_msg(1);
        put8("U"); put_n(0, 4); put8("K"); put8("T"); put_n(0, 4);
        put8("N"); put8("T"); put_n(1, 4); put8("u"); send_msg(1);
        put8("D"); put_n(0, 4); put8("E"); send_msg(1);
        put8("U"); put_n(0, 4); put8("K"); put8("T"); put_n(0, 4); put8("X"); send_msg(1);
        put8("I"); put_n(0, 4); put8("C"); put_n(2049, 2); send_msg(1);
        put8("I"); put_n(0, 4); put8("N"); put8("T"); put_n(32'hffffffff, 4); send_msg(1);
        put8("I"); put_n(0, 4); put8("Z"); send_msg(1);
        put8("I"); put_n(0, 4); put8("N"); put8("Q"); send_msg(1);
        put8("I"); put_n(0, 4); put8("N"); put8("T"); put_n(1, 4); put8("z"); send_msg(1);
        put8("I"); put_n(0, 4); put8("C"); put_n(0, 2); put8("Q"); send_msg(1);
        put8("B"); put8(0); send_msg(1);
        pending_bytes.push_back('{8'h55, 1'b0, 1'b1});

        while (pending_bytes.size() < 1350) add_random_msg();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        wait (pending_bytes.size() == 0 && !i_valid && token_q.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d bytes of begin, commit, insert, update and delete messages;",
                 bytes_sent);
        $display("checked %0d tokens, %0d of them error tokens.", tokens_seen, error_tokens);
        if (mismatches == 0 && token_q.size() == 0) begin
            $display("change_record_stream_parser_core test passed");
        end else begin
            $display("change_record_stream_parser_core test failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        byte_item_t w;
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                parse_byte(i_data_byte, i_first_byte, i_final_byte);
                bytes_sent++;
            end
            if (send_wait > 0) begin
                send_wait--;
                i_valid <= 0;
            end else if (pending_bytes.size() > 0) begin
                w = pending_bytes.pop_front();
                i_data_byte <= w.data;
                i_first_byte <= w.first;
                i_final_byte <= w.last;
                i_valid <= 1;
                send_wait = pick_wait(send_calm);
            end else begin
                i_valid <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_token e;
        cycles++;
        if (cycles > CycleLimit) begin
            $display("change_record_stream_parser_core test failed");
            $finish;
        end
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                tokens_seen++;
                if (o_token_kind == TK_ERROR) error_tokens++;
                if (token_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected token kind %0d value %h", o_token_kind,
                                 o_token_value);
                end else begin
                    e = token_q.pop_front();
                    if (o_token_kind !== e.kind || o_token_value !== e.value ||
                        o_item_index !== e.index || o_error_code !== e.err ||
                        o_string_last !== e.slast || o_message_end !== e.mend) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("token mismatch: exp %0d/%h/%0d/%0d/%b/%b got %0d/%h/%0d/%0d/%b/%b",
                                     e.kind, e.value, e.index, e.err, e.slast, e.mend,
                                     o_token_kind, o_token_value, o_item_index,
                                     o_error_code, o_string_last, o_message_end);
                    end
                end
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_stall <= 1;
            end else begin
                recv_wait = pick_wait(recv_calm);
                i_stall <= (recv_wait > 0);
                if (recv_wait > 0) recv_wait--;
            end
        end
    end
endmodule

// ===== sim.f =====
+incdir+design
design/crsp_pkg.sv
design/crsp_front.sv
design/crsp_back.sv
design/change_record_stream_parser_core.sv
tb/tb_top.sv
